FILE: design/assert_macros.svh
// Assertion macros shared by the point-in-polygon RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that prop holds at every clock edge outside reset.
`define PIC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Check that prop never holds at a clock edge outside reset.
`define PIC_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define PIC_ASSERT(lbl, clk, rstn, prop)
`define PIC_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

FILE: design/pic_pkg.sv
// Types, codes and widths shared by the point-in-polygon block.
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

  localparam int MaxVertices = 64;
  localparam int MinVertices = 3;
  localparam int CoordW      = 16;
  localparam int DiffW       = CoordW + 1;
  localparam int ProdW       = 2 * DiffW;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } pic_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_FEW = 2'd1,
    STAT_OVF = 2'd2
  } pic_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_FETCH,
    ST_MULA,
    ST_MULB,
    ST_CMP
  } pic_state_e;

  typedef enum logic [1:0] {
    PH_WEDGE1,
    PH_WEDGEN,
    PH_SEARCH,
    PH_EDGE
  } pic_phase_e;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
  } pic_in_t;

  typedef struct packed {
    logic       inside_res;
    logic [1:0] status;
  } pic_out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } pic_vtx_t;

  // Step strobes for the shared cross-product unit.
  typedef struct packed {
    logic mul_a;
    logic mul_b;
  } pic_xctl_t;

  // Sign of the last cross product.
  typedef struct packed {
    logic neg;
    logic zero;
  } pic_xsign_t;

endpackage

`default_nettype wire

FILE: design/pic_cross.sv
// Shared cross-product sign unit: one multiplier used for both products.
`timescale 1ns / 1ps
`default_nettype none

module pic_cross (
  input  logic                              clk_i,
  input  pic_pkg::pic_xctl_t                ctl_i,
  input  logic signed [pic_pkg::DiffW-1:0]  ux_i,
  input  logic signed [pic_pkg::DiffW-1:0]  uy_i,
  input  logic signed [pic_pkg::DiffW-1:0]  vx_i,
  input  logic signed [pic_pkg::DiffW-1:0]  vy_i,
  output pic_pkg::pic_xsign_t               sign_o
);

  import pic_pkg::*;

  logic signed [DiffW-1:0] op_a;
  logic signed [DiffW-1:0] op_b;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] p_q;
  logic signed [ProdW-1:0] q_q;

  // Pick ux*vy in the first step, uy*vx in the second
  always_comb begin
    if (ctl_i.mul_b) begin
      op_a = uy_i;
      op_b = vx_i;
    end else begin
      op_a = ux_i;
      op_b = vy_i;
    end
  end

  assign prod = op_a * op_b;

  // Hold each product for the compare step
  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_a) begin
      p_q <= prod;
    end
    if (ctl_i.mul_b) begin
      q_q <= prod;
    end
  end

  // Sign of ux*vy - uy*vx
  assign sign_o.neg  = (p_q < q_q);
  assign sign_o.zero = (p_q == q_q);

endmodule

`default_nettype wire

FILE: design/point_in_convex_polygon.sv
// Top level: vertex table, query sequencer and result register.
// Clear and append complete in the idle state and never raise busy; no result.
// A query on fewer than three vertices strobes its result in the cycle after start.
// A full query holds busy through the wedge test, about log2(n-2) binary-search
// steps and an outer-edge test, and strobes as busy drops; each cross product
// costs a table read, two passes through the shared multiplier and a compare.
// Reset clears vertex count, overflow flag and sequencer; table contents stay.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module point_in_convex_polygon #(
  parameter int MAX_VERTICES = pic_pkg::MaxVertices
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pic_pkg::pic_in_t  item_i,
  output logic              done_o,
  output pic_pkg::pic_out_t result_o
);

  import pic_pkg::*;

  localparam int AddrW = $clog2(MAX_VERTICES);
  localparam int CntW  = $clog2(MAX_VERTICES + 1);

  // Vertex table
  pic_vtx_t mem_q [MAX_VERTICES];
  pic_vtx_t rd_data_q;
  logic [AddrW-1:0] rd_addr;
  logic mem_we;

  // Control state
  pic_state_e state_q, state_d;
  pic_phase_e phase_q, phase_d;
  logic [CntW-1:0] count_q, count_d;
  logic ovf_q, ovf_d;
  logic done_q, done_d;

  // Datapath state
  logic signed [CoordW-1:0] px_q, px_d, py_q, py_d;
  logic signed [CoordW-1:0] base_x_q, base_x_d, base_y_q, base_y_d;
  logic signed [DiffW-1:0] vx_q, vx_d, vy_q, vy_d;
  logic signed [DiffW-1:0] ux_q, ux_d, uy_q, uy_d;
  logic [AddrW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  pic_out_t res_q, res_d;

  pic_xctl_t  xctl;
  pic_xsign_t xsign;
  logic [CntW-1:0] cnt_m1;

  assign cnt_m1 = count_q - CntW'(1);

  // Shared cross-product unit
  pic_cross u_cross (
    .clk_i  (clk_i),
    .ctl_i  (xctl),
    .ux_i   (ux_q),
    .uy_i   (uy_q),
    .vx_i   (vx_q),
    .vy_i   (vy_q),
    .sign_o (xsign)
  );

  // Sequence commands and the query steps
  always_comb begin
    logic [AddrW-1:0] nlo;
    logic [AddrW-1:0] nhi;
    logic [AddrW:0]   nsum;
    state_d  = state_q;
    phase_d  = phase_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    done_d   = 1'b0;
    px_d     = px_q;
    py_d     = py_q;
    base_x_d = base_x_q;
    base_y_d = base_y_q;
    vx_d     = vx_q;
    vy_d     = vy_q;
    ux_d     = ux_q;
    uy_d     = uy_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    res_d    = res_q;
    rd_addr  = '0;
    mem_we   = 1'b0;
    xctl     = '0;
    nlo      = lo_q;
    nhi      = hi_q;
    nsum     = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (item_i.cmd)
            CMD_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
            end
            CMD_APPEND: begin
              if (count_q < CntW'(MAX_VERTICES)) begin
                mem_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_QUERY: begin
              if (count_q < CntW'(MinVertices)) begin
                done_d           = 1'b1;
                res_d.inside_res = 1'b0;
                res_d.status     = STAT_FEW;
              end else begin
                px_d    = item_i.point_x;
                py_d    = item_i.point_y;
                lo_d    = AddrW'(1);
                hi_d    = cnt_m1[AddrW-1:0];
                phase_d = PH_WEDGE1;
                rd_addr = '0;
                state_d = ST_BASE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_BASE: begin
        // Latch the fan apex (or edge start) and the vector to the point
        base_x_d = rd_data_q.x;
        base_y_d = rd_data_q.y;
        vx_d     = DiffW'(px_q) - DiffW'(rd_data_q.x);
        vy_d     = DiffW'(py_q) - DiffW'(rd_data_q.y);
        if (phase_q == PH_EDGE) begin
          rd_addr = lo_q + AddrW'(1);
        end else begin
          rd_addr = AddrW'(1);
        end
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        ux_d    = DiffW'(rd_data_q.x) - DiffW'(base_x_q);
        uy_d    = DiffW'(rd_data_q.y) - DiffW'(base_y_q);
        state_d = ST_MULA;
      end
      ST_MULA: begin
        xctl.mul_a = 1'b1;
        state_d    = ST_MULB;
      end
      ST_MULB: begin
        xctl.mul_b = 1'b1;
        state_d    = ST_CMP;
      end
      ST_CMP: begin
        case (phase_q)
          PH_WEDGE1: begin
            if (xsign.neg) begin
              done_d           = 1'b1;
              res_d.inside_res = 1'b0;
              res_d.status     = ovf_q ? STAT_OVF : STAT_OK;
              state_d          = ST_IDLE;
            end else begin
              rd_addr = hi_q;
              phase_d = PH_WEDGEN;
              state_d = ST_FETCH;
            end
          end
          PH_WEDGEN, PH_SEARCH: begin
            if (phase_q == PH_SEARCH) begin
              if (!xsign.neg) begin
                nlo = mid_q;
              end else begin
                nhi = mid_q;
              end
            end
            if (phase_q == PH_WEDGEN && !xsign.neg && !xsign.zero) begin
              done_d           = 1'b1;
              res_d.inside_res = 1'b0;
              res_d.status     = ovf_q ? STAT_OVF : STAT_OK;
              state_d          = ST_IDLE;
            end else begin
              lo_d = nlo;
              hi_d = nhi;
              nsum = {1'b0, nlo} + {1'b0, nhi};
              if ({1'b0, nhi} > ({1'b0, nlo} + (AddrW + 1)'(1))) begin
                // Narrow the fan around the midpoint ray
                mid_d   = nsum[AddrW:1];
                rd_addr = nsum[AddrW:1];
                phase_d = PH_SEARCH;
                state_d = ST_FETCH;
              end else begin
                // Triangle found: test its outer edge
                rd_addr = nlo;
                phase_d = PH_EDGE;
                state_d = ST_BASE;
              end
            end
          end
          PH_EDGE: begin
            done_d           = 1'b1;
            res_d.inside_res = !xsign.neg;
            res_d.status     = ovf_q ? STAT_OVF : STAT_OK;
            state_d          = ST_IDLE;
          end
          default: ;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_WEDGE1;
      count_q <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    px_q     <= px_d;
    py_q     <= py_d;
    base_x_q <= base_x_d;
    base_y_q <= base_y_d;
    vx_q     <= vx_d;
    vy_q     <= vy_d;
    ux_q     <= ux_d;
    uy_q     <= uy_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    res_q    <= res_d;
  end

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[AddrW-1:0]] <= '{x: item_i.point_x, y: item_i.point_y};
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  `PIC_ASSERT(a_busy_has_hull, clk_i, rst_ni, busy |-> count_q >= CntW'(MinVertices))
  `PIC_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(MAX_VERTICES))
  `PIC_ASSERT(a_mid_between, clk_i, rst_ni, (state_q == ST_CMP && phase_q == PH_SEARCH) |-> (lo_q < mid_q && mid_q < hi_q))
  `PIC_ASSERT(a_ovf_status, clk_i, rst_ni, (done_o && result_o.status == STAT_OVF) |-> ovf_q)

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Testbench for point_in_convex_polygon: directed and random hull items checked by a local predictor.
`timescale 1ns / 1ps

module testbench;
  import pic_pkg::*;

  localparam logic [1:0] CmdUnused   = 2'd3;
  localparam int         ClkHalf     = 10;
  localparam int         ResetCycles = 5;
  localparam int         RandomItems = 1700;
  localparam int         StallLimit  = 2000;
  localparam int         DrainCycles = 60;
  localparam int         CoordMax    = 32767;
  localparam int         CoordMin    = -32768;
  localparam real        Pi          = 3.14159265358979;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  pic_in_t  item_i = '0;
  logic     busy;
  logic     done_o;
  pic_out_t result_o;

  point_in_convex_polygon i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Predictor copy of the vertex table
  logic signed [CoordW-1:0] hull_x [MaxVertices];
  logic signed [CoordW-1:0] hull_y [MaxVertices];
  int       hull_count   = 0;
  bit       hull_ovf     = 1'b0;
  pic_out_t verdict_fifo [$];

  int fail_cnt     = 0;
  int items_sent   = 0;
  bit idle_on      = 1'b0;
  int stall_cycles = 0;

  // Free-running clock
  initial begin
    forever #ClkHalf clk_i = ~clk_i;
  end

  // Sign of ux*vy - uy*vx; products of 17-bit differences fit in 64 bits
  function automatic int turn_dir(longint ux, longint uy, longint vx, longint vy);
    longint d;
    d = ux * vy - uy * vx;
    if (d == 0) return 0;
    return (d < 0) ? -1 : 1;
  endfunction

  // Wedge test at vertex 0, fan search, then the outer edge of the found triangle
  function automatic logic hull_contains(longint px, longint py);
    longint x0, y0, vx, vy;
    int     lo, hi, mid, n;
    n  = hull_count;
    x0 = hull_x[0];
    y0 = hull_y[0];
    vx = px - x0;
    vy = py - y0;
    lo = 1;
    hi = n - 1;
    if (turn_dir(longint'(hull_x[1]) - x0, longint'(hull_y[1]) - y0, vx, vy) < 0)
      return 1'b0;
    if (turn_dir(longint'(hull_x[n-1]) - x0, longint'(hull_y[n-1]) - y0, vx, vy) > 0)
      return 1'b0;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (turn_dir(longint'(hull_x[mid]) - x0, longint'(hull_y[mid]) - y0, vx, vy) >= 0)
        lo = mid;
      else
        hi = mid;
    end
    return turn_dir(longint'(hull_x[lo+1]) - longint'(hull_x[lo]),
                    longint'(hull_y[lo+1]) - longint'(hull_y[lo]),
                    px - longint'(hull_x[lo]), py - longint'(hull_y[lo])) >= 0;
  endfunction

  // Advance the predictor by one accepted item; queue a verdict for a query
  function automatic void hull_step(pic_in_t it);
    pic_out_t v;
    case (it.cmd)
      CMD_CLEAR: begin
        hull_count = 0;
        hull_ovf   = 1'b0;
      end
      CMD_APPEND: begin
        if (hull_count < MaxVertices) begin
          hull_x[hull_count] = it.point_x;
          hull_y[hull_count] = it.point_y;
          hull_count++;
        end else begin
          hull_ovf = 1'b1;
        end
      end
      CMD_QUERY: begin
        if (hull_count < MinVertices) begin
          v.inside_res = 1'b0;
          v.status     = STAT_FEW;
        end else begin
          v.inside_res = hull_contains(it.point_x, it.point_y);
          v.status     = hull_ovf ? STAT_OVF : STAT_OK;
        end
        verdict_fifo = {verdict_fifo, v};
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [CoordW-1:0] coord(int v);
    if (v > CoordMax) v = CoordMax;
    else if (v < CoordMin) v = CoordMin;
    return v[CoordW-1:0];
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Drive one item, after a random gap if idle gaps are on, and hold it until accepted
  task automatic send_item(input logic [1:0] cmd, input int x, input int y);
    pic_in_t it;
    int      gap;
    it.cmd     = cmd;
    it.point_x = coord(x);
    it.point_y = coord(y);
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    hull_step(it);
    if (cmd != CmdUnused) items_sent++;
  endtask

  // Append n vertices on a circle at sorted random angles (counter-clockwise)
  task automatic append_ring(input int n);
    real ang [MaxVertices];
    real total, acc;
    int  r, cx, cy, k;
    total = 0.0;
    for (k = 0; k < n; k++) begin
      ang[k] = real'($urandom_range(1, 100));
      total += ang[k];
    end
    r   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 600) : $urandom_range(600, CoordMax);
    cx  = int'($urandom_range(0, 2 * (CoordMax - r))) - (CoordMax - r);
    cy  = int'($urandom_range(0, 2 * (CoordMax - r))) - (CoordMax - r);
    acc = real'($urandom_range(0, 359)) * Pi / 180.0;
    for (k = 0; k < n; k++) begin
      send_item(CMD_APPEND, int'(cx + r * $cos(acc)), int'(cy + r * $sin(acc)));
      acc += 2.0 * Pi * ang[k] / total;
    end
  endtask

  // Query a point placed relative to the stored vertices
  task automatic query_hull_point();
    int mode, i, j, t, x, y;
    mode = (hull_count == 0) ? 0 : $urandom_range(0, 5);
    i = 0;
    j = 0;
    if (hull_count > 0) begin
      i = $urandom_range(0, hull_count - 1);
      j = (i + 1) % hull_count;
    end
    case (mode)
      0: begin
        x = rand_coord();
        y = rand_coord();
      end
      1: begin
        x = hull_x[i];
        y = hull_y[i];
      end
      2: begin
        x = (int'(hull_x[i]) + int'(hull_x[j])) / 2;
        y = (int'(hull_y[i]) + int'(hull_y[j])) / 2;
      end
      3: begin
        x = int'(hull_x[i]) + int'($urandom_range(0, 6)) - 3;
        y = int'(hull_y[i]) + int'($urandom_range(0, 6)) - 3;
      end
      4: begin
        x = (int'(hull_x[0]) + int'(hull_x[i]) + int'(hull_x[j])) / 3;
        y = (int'(hull_y[0]) + int'(hull_y[i]) + int'(hull_y[j])) / 3;
      end
      default: begin
        // Walk from vertex 0 toward vertex i, sometimes past it
        t = $urandom_range(0, 20);
        x = int'(hull_x[0]) + (int'(hull_x[i]) - int'(hull_x[0])) * t / 16;
        y = int'(hull_y[0]) + (int'(hull_y[i]) - int'(hull_y[0])) * t / 16;
      end
    endcase
    send_item(CMD_QUERY, x, y);
  endtask

  // Queries on empty, one- and two-vertex tables, plus an unused command
  task automatic test_short_table();
    send_item(CMD_QUERY, 0, 0);
    send_item(CMD_APPEND, 0, 0);
    send_item(CMD_QUERY, 5, 5);
    send_item(CMD_APPEND, 10, 0);
    send_item(CmdUnused, -1, -1);
    send_item(CMD_QUERY, 5, 0);
  endtask

  // Square at the coordinate extremes: every point is inside or on it
  task automatic test_extreme_square();
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_APPEND, CoordMin, CoordMin);
    send_item(CMD_APPEND, CoordMax, CoordMin);
    send_item(CMD_APPEND, CoordMax, CoordMax);
    send_item(CMD_APPEND, CoordMin, CoordMax);
    send_item(CMD_QUERY, CoordMin, CoordMin);
    send_item(CMD_QUERY, CoordMax, CoordMax);
    send_item(CMD_QUERY, 0, 0);
    send_item(CMD_QUERY, CoordMax, -1);
  endtask

  // Triangle: interior, boundary, vertices and both wedge rejections
  task automatic test_triangle();
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_APPEND, 0, 0);
    send_item(CMD_APPEND, 100, 0);
    send_item(CMD_APPEND, 0, 100);
    send_item(CMD_QUERY, 10, 10);
    send_item(CMD_QUERY, 50, 50);
    send_item(CMD_QUERY, 51, 50);
    send_item(CMD_QUERY, -1, 5);
    send_item(CMD_QUERY, 5, -1);
    send_item(CMD_QUERY, 100, 0);
    send_item(CmdUnused, 20, 20);
    send_item(CMD_QUERY, 0, 100);
  endtask

  // Clockwise, non-convex table still runs the same sequence of tests
  task automatic test_bad_table();
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_APPEND, 0, 0);
    send_item(CMD_APPEND, 0, 100);
    send_item(CMD_APPEND, 100, 0);
    send_item(CMD_APPEND, 10, 10);
    send_item(CMD_QUERY, 20, 20);
    send_item(CMD_QUERY, 5, 50);
  endtask

  // Fill the table, append past it, then clear the sticky flag
  task automatic test_overflow();
    send_item(CMD_CLEAR, 0, 0);
    append_ring(MaxVertices);
    send_item(CMD_APPEND, rand_coord(), rand_coord());
    send_item(CMD_APPEND, CoordMax, CoordMin);
    query_hull_point();
    query_hull_point();
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_QUERY, 0, 0);
  endtask

  // Mostly well-formed hulls with queries; some noise, short and full tables
  task automatic test_random_hulls();
    int target, kind, n, s;
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 99);
      if (kind < 75) begin
        s = $urandom_range(0, 19);
        n = (s < 16) ? $urandom_range(3, 8) :
            (s < 19) ? $urandom_range(9, 32) : $urandom_range(33, MaxVertices);
        send_item(CMD_CLEAR, rand_coord(), rand_coord());
        append_ring(n);
        repeat ($urandom_range(3, 12)) query_hull_point();
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 3))
            0: send_item(CMD_APPEND, rand_coord(), rand_coord());
            1: query_hull_point();
            2: send_item(CmdUnused, rand_coord(), rand_coord());
            default: send_item(CMD_QUERY, rand_coord(), rand_coord());
          endcase
        end
      end else if (kind < 95) begin
        send_item(CMD_CLEAR, rand_coord(), rand_coord());
        repeat ($urandom_range(0, 2)) send_item(CMD_APPEND, rand_coord(), rand_coord());
        repeat ($urandom_range(1, 3)) query_hull_point();
      end else begin
        send_item(CMD_CLEAR, rand_coord(), rand_coord());
        append_ring(MaxVertices);
        repeat ($urandom_range(1, 3)) send_item(CMD_APPEND, rand_coord(), rand_coord());
        repeat ($urandom_range(2, 5)) query_hull_point();
      end
    end
  endtask

  // Compare each strobed result with the oldest pending verdict
  always @(posedge clk_i) begin : check_verdicts
    pic_out_t want;
    if (rst_ni && done_o) begin
      if (verdict_fifo.size() == 0) begin
        $display("%0t: result with no query pending: inside_res %0b status %0d",
                 $time, result_o.inside_res, result_o.status);
        fail_cnt++;
      end else begin
        want = verdict_fifo.pop_front();
        if (result_o.inside_res !== want.inside_res) begin
          $display("%0t: inside_res mismatch: expected %0b, actual %0b",
                   $time, want.inside_res, result_o.inside_res);
          fail_cnt++;
        end
        if (result_o.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, result_o.status);
          fail_cnt++;
        end
      end
    end
  end

  // End the run when nothing is accepted for too long
  initial begin : watchdog
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t: no item or result accepted for %0d cycles", $time, StallLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // Reset once, run the tests in turn, drain and report
  initial begin : run_tests
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_on = 1'b0;
    test_short_table();
    idle_on = 1'b1;
    test_extreme_square();
    test_triangle();
    test_bad_table();
    test_overflow();
    test_random_hulls();
    @(negedge clk_i);
    start <= 1'b0;
    while (verdict_fifo.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
